[hw/rtl/position_ramp_power_profile_unit_defines.svh]
// Assertion macros shared by the power profile RTL.
// Plain text header, no dependencies.
`ifndef POSITION_RAMP_POWER_PROFILE_UNIT_DEFINES_SVH
`define POSITION_RAMP_POWER_PROFILE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define PRPP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define PRPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/prpp_pkg.sv]
// Types and constants for the position ramp power profile unit.
// No dependencies.
package prpp_pkg;

    localparam int POS_W   = 24;
    localparam int PWR_W   = 7;
    localparam int DV_W    = 10;
    localparam int CFG_A_W = 3;
    localparam int QUO_W   = 31;   // |24-bit difference| * 100 fits in 31 bits

    // register indexes
    localparam logic [CFG_A_W-1:0] REG_START       = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_STOP        = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_ACCEL_END   = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_DECEL_BEGIN = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_ACCEL_LEN   = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_DECEL_LEN   = 3'd5;
    localparam logic [CFG_A_W-1:0] REG_MAX_POWER   = 3'd6;
    localparam logic [CFG_A_W-1:0] REG_EDGE_POWERS = 3'd7;

    // direction codes
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_POS  = 2'd1;
    localparam logic [1:0] DIR_NEG  = 2'd2;

    localparam logic [25:0]      POS_TOL    = 26'd4;
    localparam logic [PWR_W:0]   POWER_STEP = 8'd5;
    localparam logic [PWR_W-1:0] PWR_FULL   = 7'd100;
    localparam logic [4:0]       DIV_LAST   = 5'(QUO_W - 1);

    // drive value = power * 1023 / 100, done as power * round_up(1023 * 2^24 / 100) >> 24;
    // error stays under 0.005 for power <= 127, so the floor is exact
    localparam logic [27:0] DV_RECIP = 28'd171630920;
    localparam logic [DV_W-1:0] DV_MAX = 10'd1023;

    typedef enum logic [1:0] {
        ZN_STOP,
        ZN_ACCEL,
        ZN_DECEL,
        ZN_CRUISE
    } zone_t;

endpackage

[hw/rtl/position_ramp_power_profile_unit.sv]
// Position ramp power profile unit: direction, ramped power percent and drive value.
// Depends on prpp_pkg and position_ramp_power_profile_unit_defines.svh.

// One input word is one control tick: position and drive enable. The unit updates
// the drive direction, ramps the power percent from the distance to the start point
// (acceleration zone) or stop point (deceleration zone), and returns one result word
// per tick. A tick in a ramp zone passes the direction, zone, divider, power and scale
// states: the ramp ratio runs through a restoring divider that yields one quotient bit
// per cycle over 31 bits. Cruise and stopped ticks skip the divider. The unit takes one
// word at a time; a finished result may wait in the output register while the next word
// is accepted. The user must write configuration only while idle; the unit does not check it.
`include "position_ramp_power_profile_unit_defines.svh"

module position_ramp_power_profile_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [prpp_pkg::CFG_A_W-1:0]      cfg_addr,
    input  logic [prpp_pkg::POS_W-1:0]        cfg_data,
    // input words
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,  // position[23:0], drive_enable[24]
    // result words
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // direction[1:0], power_percent[8:2], drive_value[18:9],
    // power_changed[19], restart_request[20]
    output logic [23:0]                       m_axis_tdata
);
    import prpp_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIR   = 6'b000010,
        S_ZONE  = 6'b000100,
        S_DIV   = 6'b001000,
        S_POWER = 6'b010000,
        S_SCALE = 6'b100000
    } state_t;

    // configuration registers
    logic [POS_W-1:0]   start_reg, stop_reg, accel_end_reg, decel_begin_reg;
    logic [POS_W-1:0]   accel_len_reg, decel_len_reg;
    logic [PWR_W-1:0]   max_power_reg;
    logic [2*PWR_W-1:0] edge_powers_reg;

    // sequencer and working registers
    state_t             state_reg, state_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               en_reg, en_next;
    logic [1:0]         dir_reg, dir_next;
    logic [PWR_W-1:0]   power_reg, power_next;
    logic               restart_reg, restart_next;
    logic               changed_reg, changed_next;
    zone_t              zone_reg, zone_next;
    logic               neg_reg, neg_next;
    logic [POS_W-1:0]   div_reg, div_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [POS_W-1:0]   rem_reg, rem_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [23:0]        out_data_reg, out_data_next;

    // combinational helpers
    logic signed [POS_W:0] stop_diff;
    logic                  in_window;
    logic                  restart_pos, restart_neg;
    logic                  accel_c, decel_c;
    logic [POS_W-1:0]      minuend, subtrahend, len_sel;
    logic signed [POS_W:0] num_diff;
    logic [POS_W-1:0]      num_mag;
    logic [QUO_W-1:0]      num_x100;
    logic [POS_W+1:0]      trial;
    logic                  trial_ok;
    logic                  raw_neg, raw_big, ge_max, lt_min, hold_step;
    logic [PWR_W-1:0]      raw7, min_pwr, pwr_pick;
    logic [34:0]           dv_prod;
    logic [DV_W-1:0]       dv;
    logic                  out_free;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg       <= '0;
            stop_reg        <= '0;
            accel_end_reg   <= '0;
            decel_begin_reg <= '0;
            accel_len_reg   <= 24'd1;
            decel_len_reg   <= 24'd1;
            max_power_reg   <= PWR_FULL;
            edge_powers_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_START:       start_reg       <= cfg_data;
                REG_STOP:        stop_reg        <= cfg_data;
                REG_ACCEL_END:   accel_end_reg   <= cfg_data;
                REG_DECEL_BEGIN: decel_begin_reg <= cfg_data;
                REG_ACCEL_LEN:   accel_len_reg   <= cfg_data;
                REG_DECEL_LEN:   decel_len_reg   <= cfg_data;
                REG_MAX_POWER:   max_power_reg   <= cfg_data[PWR_W-1:0];
                REG_EDGE_POWERS: edge_powers_reg <= cfg_data[2*PWR_W-1:0];
                default:         ;
            endcase
        end
    end

    // direction window and restart checks
    always_comb
    begin
        stop_diff   = $signed({1'b0, pos_reg}) - $signed({1'b0, stop_reg});
        in_window   = (stop_diff >= -$signed(POS_TOL[POS_W:0]))
                   && (stop_diff <= $signed(POS_TOL[POS_W:0]));
        restart_pos = ({2'b00, pos_reg} + POS_TOL) < {2'b00, start_reg};
        restart_neg = {2'b00, pos_reg} > ({2'b00, start_reg} + POS_TOL);
    end

    // zone decision and ramp numerator
    always_comb
    begin
        if (dir_reg == DIR_NEG)
        begin
            accel_c = pos_reg > accel_end_reg;
            decel_c = pos_reg <= decel_begin_reg;
        end
        else
        begin
            accel_c = pos_reg < accel_end_reg;
            decel_c = pos_reg >= decel_begin_reg;
        end

        // accel: (pos - start) * 100, decel: (stop - pos) * 100; operands swap for DIR_NEG
        if (accel_c)
        begin
            minuend    = (dir_reg == DIR_NEG) ? start_reg : pos_reg;
            subtrahend = (dir_reg == DIR_NEG) ? pos_reg : start_reg;
            len_sel    = accel_len_reg;
        end
        else
        begin
            minuend    = (dir_reg == DIR_NEG) ? pos_reg : stop_reg;
            subtrahend = (dir_reg == DIR_NEG) ? stop_reg : pos_reg;
            len_sel    = decel_len_reg;
        end

        num_diff = $signed({1'b0, minuend}) - $signed({1'b0, subtrahend});
        num_mag  = num_diff[POS_W] ? POS_W'(-num_diff) : num_diff[POS_W-1:0];
        num_x100 = ({7'd0, num_mag} << 6) + ({7'd0, num_mag} << 5) + ({7'd0, num_mag} << 2);
    end

    // divider step: one quotient bit per cycle
    always_comb
    begin
        trial    = {1'b0, rem_reg, quo_reg[QUO_W-1]} - {2'b00, div_reg};
        trial_ok = !trial[POS_W+1];
    end

    // power selection from the quotient
    always_comb
    begin
        raw_neg = neg_reg && (quo_reg != '0);
        raw_big = |quo_reg[QUO_W-1:PWR_W];
        raw7    = quo_reg[PWR_W-1:0];
        ge_max  = raw_big || (raw7 >= max_power_reg);
        min_pwr = (zone_reg == ZN_DECEL) ? edge_powers_reg[2*PWR_W-1:PWR_W]
                                         : edge_powers_reg[PWR_W-1:0];
        lt_min  = raw7 < min_pwr;
        if (zone_reg == ZN_DECEL)
            hold_step = {1'b0, power_reg} < ({1'b0, raw7} + POWER_STEP);
        else
            hold_step = ({1'b0, power_reg} + POWER_STEP) > {1'b0, raw7};

        case (zone_reg)
            ZN_STOP:   pwr_pick = '0;
            ZN_CRUISE: pwr_pick = max_power_reg;
            default:
            begin
                if (raw_neg)
                    pwr_pick = power_reg;
                else if (ge_max)
                    pwr_pick = max_power_reg;
                else if (lt_min)
                    pwr_pick = min_pwr;
                else if (hold_step)
                    pwr_pick = power_reg;
                else
                    pwr_pick = raw7;
            end
        endcase
    end

    // drive value scaling
    always_comb
    begin
        dv_prod = 35'(power_reg) * 35'(DV_RECIP);
        dv      = (dv_prod[34:24] > {1'b0, DV_MAX}) ? DV_MAX : dv_prod[33:24];
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        en_next        = en_reg;
        dir_next       = dir_reg;
        power_next     = power_reg;
        restart_next   = restart_reg;
        changed_next   = changed_reg;
        zone_next      = zone_reg;
        neg_next       = neg_reg;
        div_next       = div_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    pos_next   = s_axis_tdata[POS_W-1:0];
                    en_next    = s_axis_tdata[POS_W];
                    state_next = S_DIR;
                end
            end
            S_DIR:
            begin
                restart_next = 1'b0;
                if (en_reg)
                begin
                    if (in_window)
                        dir_next = DIR_STOP;
                    else if (stop_diff[POS_W])
                    begin
                        dir_next     = DIR_POS;
                        restart_next = restart_pos;
                    end
                    else
                    begin
                        dir_next     = DIR_NEG;
                        restart_next = restart_neg;
                    end
                end
                state_next = S_ZONE;
            end
            S_ZONE:
            begin
                neg_next = num_diff[POS_W];
                quo_next = num_x100;
                rem_next = '0;
                cnt_next = '0;
                div_next = (len_sel == '0) ? POS_W'(1) : len_sel;
                if (dir_reg == DIR_STOP)
                begin
                    zone_next  = ZN_STOP;
                    state_next = S_POWER;
                end
                else if (accel_c)
                begin
                    zone_next  = ZN_ACCEL;
                    state_next = S_DIV;
                end
                else if (decel_c)
                begin
                    zone_next  = ZN_DECEL;
                    state_next = S_DIV;
                end
                else
                begin
                    zone_next  = ZN_CRUISE;
                    state_next = S_POWER;
                end
            end
            S_DIV:
            begin
                rem_next = trial_ok ? trial[POS_W-1:0]
                                    : {rem_reg[POS_W-2:0], quo_reg[QUO_W-1]};
                quo_next = {quo_reg[QUO_W-2:0], trial_ok};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_POWER;
                end
            end
            S_POWER:
            begin
                power_next   = (pwr_pick > PWR_FULL) ? PWR_FULL : pwr_pick;
                changed_next = (power_next != power_reg);
                state_next   = S_SCALE;
            end
            S_SCALE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'b000, restart_reg, changed_reg, dv, power_reg, dir_reg};
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dir_reg       <= DIR_STOP;
            power_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dir_reg       <= dir_next;
            power_reg     <= power_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        en_reg       <= en_next;
        restart_reg  <= restart_next;
        changed_reg  <= changed_next;
        zone_reg     <= zone_next;
        neg_reg      <= neg_next;
        div_reg      <= div_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        out_data_reg <= out_data_next;
    end

    // checks
    `PRPP_ASSERT_NOW(a_power_range, out_valid_reg,
        out_data_reg[8:2] <= PWR_FULL, "power above 100")
    `PRPP_ASSERT_NOW(a_dir_code, out_valid_reg, out_data_reg[1:0] != 2'd3, "bad direction code")
    `PRPP_ASSERT_NEXT(a_div_done, (state_reg == S_DIV) && (cnt_reg == DIV_LAST),
        state_reg == S_POWER, "divider overran")
    `PRPP_ASSERT_NEXT(a_stop_zero, (state_reg == S_POWER) && (zone_reg == ZN_STOP),
        power_reg == '0, "stopped with power")
    `PRPP_ASSERT_NOW(a_rem_bound, state_reg == S_DIV,
        rem_reg < div_reg, "remainder not below divisor")

endmodule
